FILE: rtl/fde_pkg.sv
// ----------------------------------------------------------------------------
// fde_pkg
// Types, constants and helpers shared by the directory entry decoder.
// ----------------------------------------------------------------------------
package fde_pkg;

   // directory counter width (8 to 32)
   localparam int COUNT_BITS = 16;
   localparam int CFG_BITS   = 16;
   localparam int IDX_BITS   = 16;
   localparam int CMP_BITS   = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;
   localparam int CSR_ADDR_BITS = 8;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [CFG_BITS-1:0]   cfg_type;
   typedef logic [CMP_BITS-1:0]   cmp_type;
   typedef logic [CSR_ADDR_BITS-1:0] csr_addr_type;

   // register indexes
   localparam csr_addr_type CSR_SKIP_COUNT  = csr_addr_type'(0);
   localparam csr_addr_type CSR_MAX_ENTRIES = csr_addr_type'(1);

   localparam cfg_type SKIP_COUNT_RESET  = '0;
   localparam cfg_type MAX_ENTRIES_RESET = '1;

   // result kinds
   localparam logic KIND_NAME = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // byte codes
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_DEL   = 8'hE5;
   localparam logic [7:0] ATTR_LFN   = 8'h0F;
   localparam int ATTR_VOLUME_BIT = 3;
   localparam int ATTR_DIR_BIT    = 4;

   localparam logic [3:0] NAME_MAX_LEN = 4'd12;

   // one queued beat of work for the back end
   typedef struct packed {
      logic        kind;
      logic [63:0] base;
      logic [23:0] ext;
      logic [3:0]  base_len;
      logic        has_ext;
      logic [1:0]  ext_len;
      logic        is_dir;
      logic [31:0] size;
      logic [IDX_BITS-1:0] list_index;
   } fde_entry_type;

   function automatic cmp_type count_to_cmp(count_type value);
      return cmp_type'(value);
   endfunction

   function automatic cmp_type cfg_to_cmp(cfg_type value);
      return cmp_type'(value);
   endfunction

   function automatic logic [IDX_BITS-1:0] count_to_idx(count_type value);
      logic [CMP_BITS-1:0] wide;
      wide = cmp_type'(value);
      return wide[IDX_BITS-1:0];
   endfunction

endpackage

FILE: rtl/fde_if.sv
// ----------------------------------------------------------------------------
// fde interfaces
// Valid/ready channels for entries, listing results and register writes.
// ----------------------------------------------------------------------------
interface fde_req_if;
   logic        valid;
   logic        ready;
   logic        dir_start;
   logic [63:0] name_base;
   logic [23:0] name_ext;
   logic [7:0]  attr_byte;
   logic [31:0] entry_size;

   modport source (output valid, dir_start, name_base, name_ext, attr_byte, entry_size,
                   input ready);
   modport sink   (input valid, dir_start, name_base, name_ext, attr_byte, entry_size,
                   output ready);
endinterface

interface fde_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  name_char;
   logic        last;
   logic        is_dir;
   logic [31:0] size_out;
   logic [15:0] list_index;

   modport source (output valid, kind, name_char, last, is_dir, size_out, list_index,
                   input ready);
   modport sink   (input valid, kind, name_char, last, is_dir, size_out, list_index,
                   output ready);
endinterface

interface fde_csr_if;
   logic                              valid;
   logic                              ready;
   logic [fde_pkg::CSR_ADDR_BITS-1:0] index;
   logic [fde_pkg::CFG_BITS-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/fde_front.sv
// ----------------------------------------------------------------------------
// fde_front
// Accepts entries, tracks directory counters and queues listing work.
// ----------------------------------------------------------------------------
module fde_front (
   input  logic                   clock,
   input  logic                   reset,
   fde_req_if.sink                req_ch,
   fde_csr_if.sink                csr_ch,
   input  logic                   queue_full,
   output logic                   push,
   output fde_pkg::fde_entry_type push_entry
);

   fde_pkg::cfg_type   skip_count_ff, skip_count_in;
   fde_pkg::cfg_type   max_entries_ff, max_entries_in;
   fde_pkg::count_type valid_seen_ff, valid_seen_in;
   fde_pkg::count_type listed_ff, listed_in;
   logic               dir_ended_ff, dir_ended_in;

   fde_pkg::count_type vs, lc;
   logic               de, accept, blocked, skipped, first_nul;
   logic [7:0]         first;
   logic [3:0]         zero_pos, base_len;
   logic [1:0]         ezero, ext_len;
   logic               has_ext;

   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = !queue_full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign first        = req_ch.name_base[7:0];

   // name lengths: base up to first NUL, trailing spaces dropped; same for extension
   always_comb begin
      zero_pos = 4'd8;
      for (int i = 7; i >= 0; i--) begin
         if (req_ch.name_base[8*i +: 8] == fde_pkg::CHAR_NUL) zero_pos = 4'(i);
      end
      base_len = 4'd0;
      for (int i = 0; i < 8; i++) begin
         if (4'(i) < zero_pos && req_ch.name_base[8*i +: 8] != fde_pkg::CHAR_SPACE)
            base_len = 4'(i + 1);
      end
      has_ext = req_ch.name_ext[7:0] != fde_pkg::CHAR_SPACE;
      ezero = 2'd3;
      for (int i = 2; i >= 0; i--) begin
         if (req_ch.name_ext[8*i +: 8] == fde_pkg::CHAR_NUL) ezero = 2'(i);
      end
      ext_len = 2'd0;
      for (int i = 0; i < 3; i++) begin
         if (has_ext && 2'(i) < ezero && req_ch.name_ext[8*i +: 8] != fde_pkg::CHAR_SPACE)
            ext_len = 2'(i + 1);
      end
   end

   always_comb begin
      vs = req_ch.dir_start ? '0 : valid_seen_ff;
      lc = req_ch.dir_start ? '0 : listed_ff;
      de = req_ch.dir_start ? 1'b0 : dir_ended_ff;
      blocked   = de || (fde_pkg::count_to_cmp(lc) >= fde_pkg::cfg_to_cmp(max_entries_ff));
      first_nul = first == fde_pkg::CHAR_NUL;
      skipped   = first == fde_pkg::CHAR_DEL || req_ch.attr_byte == fde_pkg::ATTR_LFN ||
                  req_ch.attr_byte[fde_pkg::ATTR_VOLUME_BIT];

      valid_seen_in = valid_seen_ff;
      listed_in     = listed_ff;
      dir_ended_in  = dir_ended_ff;
      push          = 1'b0;

      push_entry.kind       = fde_pkg::KIND_NAME;
      push_entry.base       = req_ch.name_base;
      push_entry.ext        = req_ch.name_ext;
      push_entry.base_len   = base_len;
      push_entry.has_ext    = has_ext;
      push_entry.ext_len    = ext_len;
      push_entry.is_dir     = req_ch.attr_byte[fde_pkg::ATTR_DIR_BIT];
      push_entry.size       = req_ch.entry_size;
      push_entry.list_index = fde_pkg::count_to_idx(lc);

      if (accept) begin
         valid_seen_in = vs;
         listed_in     = lc;
         dir_ended_in  = de;
         if (!blocked && first_nul) begin
            dir_ended_in        = 1'b1;
            push                = 1'b1;
            push_entry.kind     = fde_pkg::KIND_END;
            push_entry.base_len = 4'd0;
            push_entry.has_ext  = 1'b0;
            push_entry.ext_len  = 2'd0;
            push_entry.is_dir   = 1'b0;
            push_entry.size     = '0;
         end else if (!blocked && !skipped) begin
            if (fde_pkg::count_to_cmp(vs) >= fde_pkg::cfg_to_cmp(skip_count_ff)) begin
               push = 1'b1;
               if (lc != '1) listed_in = lc + 1'b1;
            end
            if (vs != '1) valid_seen_in = vs + 1'b1;
         end
      end
   end

   always_comb begin
      skip_count_in  = skip_count_ff;
      max_entries_in = max_entries_ff;
      if (csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.index)
            fde_pkg::CSR_SKIP_COUNT:  skip_count_in  = csr_ch.data;
            fde_pkg::CSR_MAX_ENTRIES: max_entries_in = csr_ch.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_count_ff  <= fde_pkg::SKIP_COUNT_RESET;
         max_entries_ff <= fde_pkg::MAX_ENTRIES_RESET;
         valid_seen_ff  <= '0;
         listed_ff      <= '0;
         dir_ended_ff   <= 1'b0;
      end else begin
         skip_count_ff  <= skip_count_in;
         max_entries_ff <= max_entries_in;
         valid_seen_ff  <= valid_seen_in;
         listed_ff      <= listed_in;
         dir_ended_ff   <= dir_ended_in;
      end
   end

endmodule

FILE: rtl/fde_queue.sv
// ----------------------------------------------------------------------------
// fde_queue
// Small FIFO of listing work between the front and back ends.
// ----------------------------------------------------------------------------
module fde_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  fde_pkg::fde_entry_type push_entry,
   input  logic                   pop,
   output fde_pkg::fde_entry_type head,
   output logic                   empty,
   output logic                   full
);

   fde_pkg::fde_entry_type slots_ff [fde_pkg::QUEUE_DEPTH];
   logic [fde_pkg::QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [fde_pkg::QPTR_BITS:0]   count_ff, count_in;
   logic                          do_push, do_pop;

   assign empty   = count_ff == '0;
   assign full    = count_ff == (fde_pkg::QPTR_BITS+1)'(fde_pkg::QUEUE_DEPTH);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) slots_ff[wr_ptr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/fde_back.sv
// ----------------------------------------------------------------------------
// fde_back
// Walks the queued entry one character per beat into the output register.
// ----------------------------------------------------------------------------
module fde_back (
   input  logic                   clock,
   input  logic                   reset,
   input  fde_pkg::fde_entry_type head,
   input  logic                   empty,
   output logic                   pop,
   fde_rsp_if.source              rsp_ch
);

   logic [3:0]  pos_ff, pos_in;
   logic        valid_ff, valid_in;
   logic        kind_ff, last_ff, is_dir_ff;
   logic [7:0]  char_ff;
   logic [31:0] size_ff;
   logic [15:0] idx_ff;

   logic        load, is_last;
   logic [3:0]  name_len, last_pos, ext_off;
   logic [7:0]  char_sel;

   assign load = !empty && (!valid_ff || rsp_ch.ready);

   always_comb begin
      name_len = head.base_len + {3'd0, head.has_ext} + {2'd0, head.ext_len};
      // a full-length name carries no terminator beat
      last_pos = (name_len < fde_pkg::NAME_MAX_LEN) ? name_len : name_len - 4'd1;
      is_last  = pos_ff == last_pos;
      ext_off  = pos_ff - head.base_len - 4'd1;
      char_sel = fde_pkg::CHAR_NUL;
      if (pos_ff < head.base_len)
         char_sel = head.base[8*pos_ff[2:0] +: 8];
      else if (head.has_ext && pos_ff == head.base_len)
         char_sel = fde_pkg::CHAR_DOT;
      else if (head.has_ext && ext_off < {2'd0, head.ext_len})
         char_sel = head.ext[8*ext_off[1:0] +: 8];
      pop = load && is_last;
   end

   always_comb begin
      pos_in   = pos_ff;
      valid_in = valid_ff;
      if (rsp_ch.ready) valid_in = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         pos_in   = is_last ? 4'd0 : pos_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= 4'd0;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff   <= head.kind;
         char_ff   <= char_sel;
         last_ff   <= is_last;
         is_dir_ff <= head.is_dir;
         size_ff   <= head.size;
         idx_ff    <= head.list_index;
      end
   end

   assign rsp_ch.valid      = valid_ff;
   assign rsp_ch.kind       = kind_ff;
   assign rsp_ch.name_char  = char_ff;
   assign rsp_ch.last       = last_ff;
   assign rsp_ch.is_dir     = is_dir_ff;
   assign rsp_ch.size_out   = size_ff;
   assign rsp_ch.list_index = idx_ff;

endmodule

FILE: rtl/fat_dir_entry_decoder_core.sv
// ----------------------------------------------------------------------------
// fat_dir_entry_decoder_core
// FAT 8.3 directory lister: one entry per beat in, one name character out.
// ----------------------------------------------------------------------------
// The front end accepts one directory entry per cycle whenever its four-deep
// work queue has room, updates the directory counters and drops deleted, long
// name, volume label, passed-over and post-end entries on the spot. The back
// end drains the queue into a registered output, one result per cycle
// while the output is ready: one beat per name character plus a NUL beat
// unless the name is full length, a single beat per end marker and none
// for a dropped entry. Registers are written through the csr
// channel, which is always ready; write them only while the block is idle.
module fat_dir_entry_decoder_core (
   input  logic      clock,
   input  logic      reset,
   fde_req_if.sink   req_ch,
   fde_rsp_if.source rsp_ch,
   fde_csr_if.sink   csr_ch
);

   fde_pkg::fde_entry_type push_entry, head;
   logic push, pop, empty, full;

   fde_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .csr_ch     (csr_ch),
      .queue_full (full),
      .push       (push),
      .push_entry (push_entry)
   );

   fde_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .empty      (empty),
      .full       (full)
   );

   fde_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .empty  (empty),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule

FILE: rtl/fde_checker.sv
// ----------------------------------------------------------------------------
// fde_checker
// Port-level checks on the listing output of the decoder.
// ----------------------------------------------------------------------------
module fde_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_kind,
   input logic [7:0]  rsp_name_char,
   input logic        rsp_last,
   input logic [31:0] rsp_size_out
);

   // stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_name_char) && $stable(rsp_last))
      else $error("rsp beat changed while stalled");

   // end marker is a single, empty beat
   a_end_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == fde_pkg::KIND_END |->
         rsp_last && rsp_name_char == fde_pkg::CHAR_NUL && rsp_size_out == 32'd0)
      else $error("malformed end marker");

   // NUL only closes a name
   a_nul_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == fde_pkg::KIND_NAME && !rsp_last |->
         rsp_name_char != fde_pkg::CHAR_NUL)
      else $error("NUL inside a name");

   // no result right after reset
   a_reset_idle: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind fat_dir_entry_decoder_core fde_checker u_fde_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_kind      (rsp_ch.kind),
   .rsp_name_char (rsp_ch.name_char),
   .rsp_last      (rsp_ch.last),
   .rsp_size_out  (rsp_ch.size_out)
);

FILE: dv/fde_listing_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fde_listing_checker
// Watches the entry, listing and register channels of the directory decoder.
// Every accepted entry beat is run through a local copy of the lister, and
// the listing beats that it must produce are queued. Each listing beat that
// the block hands over is compared field by field with the oldest one queued.
// ----------------------------------------------------------------------------
module fde_listing_checker (
   input  logic clock,
   input  logic reset,
   fde_req_if   req_mon,
   fde_rsp_if   rsp_mon,
   fde_csr_if   csr_mon,
   output int   fail_count,
   output int   pending_beats,
   output int   beats_checked
);

   typedef struct packed {
      logic        kind;
      logic [7:0]  name_char;
      logic        last;
      logic        is_dir;
      logic [31:0] size_out;
      logic [15:0] list_index;
   } listing_beat_type;

   listing_beat_type listing_q[$];

   fde_pkg::cfg_type   skip_cfg;
   fde_pkg::cfg_type   limit_cfg;
   fde_pkg::count_type valid_seen;
   fde_pkg::count_type listed_count;
   logic               dir_ended;

   // 8.3 name as shown in a listing: base up to the first NUL with trailing
   // blanks gone, then a dot and the extension unless its first byte is blank
   function automatic int normalize_name(input logic [63:0] base, input logic [23:0] ext,
                                         output logic [11:0][7:0] text);
      int         len;
      logic [7:0] c;
      bit         stop;
      text = '0;
      len  = 0;
      stop = 1'b0;
      for (int i = 0; i < 8; i++) begin
         c = base[8*i +: 8];
         if (c == fde_pkg::CHAR_NUL) stop = 1'b1;
         if (!stop) begin
            text[len] = c;
            len++;
         end
      end
      while (len > 0 && text[len-1] == fde_pkg::CHAR_SPACE) len--;
      if (ext[7:0] != fde_pkg::CHAR_SPACE) begin
         text[len] = fde_pkg::CHAR_DOT;
         len++;
         stop = 1'b0;
         for (int i = 0; i < 3; i++) begin
            c = ext[8*i +: 8];
            if (c == fde_pkg::CHAR_NUL) stop = 1'b1;
            if (!stop) begin
               text[len] = c;
               len++;
            end
         end
         while (len > 0 && text[len-1] == fde_pkg::CHAR_SPACE) len--;
      end
      return len;
   endfunction

   function automatic void predict_listing(input logic dstart, input logic [63:0] base,
                                           input logic [23:0] ext, input logic [7:0] attr,
                                           input logic [31:0] size);
      logic [11:0][7:0] text;
      int               len;
      int               n;
      listing_beat_type b;
      if (dstart) begin
         valid_seen   = '0;
         listed_count = '0;
         dir_ended    = 1'b0;
      end
      if (dir_ended || listed_count >= limit_cfg) return;
      if (base[7:0] == fde_pkg::CHAR_NUL) begin
         dir_ended    = 1'b1;
         b.kind       = fde_pkg::KIND_END;
         b.name_char  = fde_pkg::CHAR_NUL;
         b.last       = 1'b1;
         b.is_dir     = 1'b0;
         b.size_out   = '0;
         b.list_index = 16'(listed_count);
         listing_q.push_back(b);
         return;
      end
      if (base[7:0] == fde_pkg::CHAR_DEL || attr == fde_pkg::ATTR_LFN ||
          attr[fde_pkg::ATTR_VOLUME_BIT]) return;
      if (valid_seen >= skip_cfg) begin
         len = normalize_name(base, ext, text);
         n   = (len < fde_pkg::NAME_MAX_LEN) ? len + 1 : len;
         for (int k = 0; k < n; k++) begin
            b.kind       = fde_pkg::KIND_NAME;
            b.name_char  = (k < len) ? text[k] : fde_pkg::CHAR_NUL;
            b.last       = (k == n - 1);
            b.is_dir     = attr[fde_pkg::ATTR_DIR_BIT];
            b.size_out   = size;
            b.list_index = 16'(listed_count);
            listing_q.push_back(b);
         end
         if (listed_count != '1) listed_count++;
      end
      if (valid_seen != '1) valid_seen++;
   endfunction

   function automatic void check_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: listing mismatch on %s: expected 0x%0h, actual 0x%0h",
                  $time, field, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      listing_beat_type want;
      if (reset) begin
         skip_cfg     = fde_pkg::SKIP_COUNT_RESET;
         limit_cfg    = fde_pkg::MAX_ENTRIES_RESET;
         valid_seen   = '0;
         listed_count = '0;
         dir_ended    = 1'b0;
         listing_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            beats_checked++;
            if (listing_q.size() == 0) begin
               $display("%0t: unexpected listing beat: expected nothing, actual kind %0d",
                        $time, rsp_mon.kind);
               $display("   char 0x%0h index %0d", rsp_mon.name_char, rsp_mon.list_index);
               fail_count++;
            end else begin
               want = listing_q.pop_front();
               check_field("kind", want.kind, rsp_mon.kind);
               check_field("name_char", want.name_char, rsp_mon.name_char);
               check_field("last", want.last, rsp_mon.last);
               check_field("is_dir", want.is_dir, rsp_mon.is_dir);
               check_field("size_out", want.size_out, rsp_mon.size_out);
               check_field("list_index", want.list_index, rsp_mon.list_index);
            end
         end
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               fde_pkg::CSR_SKIP_COUNT:  skip_cfg  = csr_mon.data;
               fde_pkg::CSR_MAX_ENTRIES: limit_cfg = csr_mon.data;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            predict_listing(req_mon.dir_start, req_mon.name_base, req_mon.name_ext,
                            req_mon.attr_byte, req_mon.entry_size);
      end
      pending_beats <= listing_q.size();
   end

endmodule

FILE: dv/tb_fat_dir_entry_decoder_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fat_dir_entry_decoder_core
// Stimulus and verdict for the FAT directory entry lister.
// A directed set of entries covers name trimming, full-length and empty names,
// skipped entry types, end markers and the skip and listing limits. Random
// directories follow under changing register settings, with random gaps on
// the entry side and random stalls on the listing side, plus one stretch with
// no gaps or stalls at all. The checker does the comparing.
// ----------------------------------------------------------------------------
module tb_fat_dir_entry_decoder_core;

   localparam int         DRAIN_CYCLES = 64;
   localparam int         RANDOM_ITEMS = 380;
   localparam logic [7:0] CHAR_A       = 8'h41;
   localparam logic [7:0] ATTR_ARCHIVE = 8'h20;
   localparam logic [7:0] VOLUME_MASK  = 8'(1 << fde_pkg::ATTR_VOLUME_BIT);
   localparam logic [7:0] DIR_MASK     = 8'(1 << fde_pkg::ATTR_DIR_BIT);

   logic clock;
   logic reset;
   bit   quiet;
   int   fail_count;
   int   pending_beats;
   int   beats_checked;
   int   entry_beats;
   int   settings;
   int   random_items;

   fde_req_if req_if ();
   fde_rsp_if rsp_if ();
   fde_csr_if csr_if ();

   fat_dir_entry_decoder_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   fde_listing_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_if),
      .rsp_mon       (rsp_if),
      .csr_mon       (csr_if),
      .fail_count    (fail_count),
      .pending_beats (pending_beats),
      .beats_checked (beats_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("%0t: timeout, %0d listing beats still expected", $time, pending_beats);
      $display("Simulation FAILED");
      $finish;
   end

   // listing side back-pressure
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= !reset && (quiet || $urandom_range(99) >= 23);
      end
   end

   function automatic logic [63:0] pack_chars(input string s);
      logic [63:0] v;
      v = {8{fde_pkg::CHAR_SPACE}};
      for (int i = 0; i < s.len() && i < 8; i++) v[8*i +: 8] = s[i];
      return v;
   endfunction

   function automatic logic [7:0] pick_char();
      case ($urandom_range(7))
         0:       return 8'($urandom_range(255, 1));
         1:       return fde_pkg::CHAR_SPACE;
         default: return CHAR_A + 8'($urandom_range(25));
      endcase
   endfunction

   function automatic logic [63:0] pick_base();
      logic [63:0] v;
      int          n;
      n = $urandom_range(8);
      for (int i = 0; i < 8; i++) v[8*i +: 8] = (i < n) ? pick_char() : fde_pkg::CHAR_SPACE;
      if ($urandom_range(9) == 0) v = {$urandom, $urandom};
      if ($urandom_range(11) == 0) v[8*$urandom_range(7) +: 8] = fde_pkg::CHAR_NUL;
      // keep the first byte an ordinary character; end and delete come separately
      if (v[7:0] == fde_pkg::CHAR_NUL || v[7:0] == fde_pkg::CHAR_DEL) v[7:0] = CHAR_A;
      return v;
   endfunction

   function automatic logic [23:0] pick_ext();
      logic [23:0] v;
      int          n;
      n = $urandom_range(3);
      for (int i = 0; i < 3; i++) v[8*i +: 8] = (i < n) ? pick_char() : fde_pkg::CHAR_SPACE;
      if ($urandom_range(7) == 0) v = 24'($urandom);
      if ($urandom_range(9) == 0) v[8*$urandom_range(2) +: 8] = fde_pkg::CHAR_NUL;
      return v;
   endfunction

   function automatic logic [7:0] pick_attr();
      case ($urandom_range(7))
         0, 1, 2: return ATTR_ARCHIVE;
         3, 4:    return DIR_MASK;
         5:       return 8'h00;
         default: return 8'($urandom) & ~VOLUME_MASK;
      endcase
   endfunction

   task automatic send_entry(input logic dstart, input logic [63:0] base,
                             input logic [23:0] ext, input logic [7:0] attr,
                             input logic [31:0] size);
      while (!quiet && $urandom_range(99) < 23) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.dir_start  <= dstart;
      req_if.name_base  <= base;
      req_if.name_ext   <= ext;
      req_if.attr_byte  <= attr;
      req_if.entry_size <= size;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
      entry_beats++;
   endtask

   // wait for the listing to drain and the queue behind it to empty
   task automatic settle();
      req_if.valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending_beats != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input fde_pkg::cfg_type skip, input fde_pkg::cfg_type limit);
      settle();
      for (int r = 0; r < 2; r++) begin
         csr_if.valid <= 1'b1;
         csr_if.index <= (r == 0) ? fde_pkg::CSR_SKIP_COUNT : fde_pkg::CSR_MAX_ENTRIES;
         csr_if.data  <= (r == 0) ? skip : limit;
         do @(posedge clock); while (!(csr_if.valid && csr_if.ready));
      end
      csr_if.valid <= 1'b0;
      settings++;
   endtask

   // one directory: entries with some deleted, long name and volume noise,
   // usually closed by an end marker and followed by a few ignored entries
   task automatic run_directory(input int count);
      logic [63:0] base;
      logic [7:0]  attr;
      for (int i = 0; i < count; i++) begin
         base = pick_base();
         attr = pick_attr();
         case ($urandom_range(9))
            0:       base[7:0] = fde_pkg::CHAR_DEL;
            1:       attr = fde_pkg::ATTR_LFN;
            2:       attr = attr | VOLUME_MASK;
            default: ;
         endcase
         send_entry(i == 0, base, pick_ext(), attr, $urandom);
         random_items++;
      end
      if ($urandom_range(4) != 0) begin
         send_entry(count == 0, {$urandom, 24'($urandom), fde_pkg::CHAR_NUL}, pick_ext(),
                    8'($urandom), $urandom);
         random_items++;
         repeat ($urandom_range(2)) begin
            send_entry(1'b0, pick_base(), pick_ext(), pick_attr(), $urandom);
            random_items++;
         end
      end
   endtask

   initial begin
      logic [63:0]      base;
      logic [23:0]      ext;
      fde_pkg::cfg_type skip;
      fde_pkg::cfg_type limit;
      int               phase;

      reset             <= 1'b1;
      quiet             = 1'b0;
      req_if.valid      <= 1'b0;
      req_if.dir_start  <= 1'b0;
      req_if.name_base  <= '0;
      req_if.name_ext   <= '0;
      req_if.attr_byte  <= '0;
      req_if.entry_size <= '0;
      csr_if.valid      <= 1'b0;
      csr_if.index      <= fde_pkg::CSR_SKIP_COUNT;
      csr_if.data       <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings list everything
      send_entry(1'b1, pack_chars("README"), 24'(pack_chars("TXT")), ATTR_ARCHIVE, 32'd1234);
      send_entry(1'b0, pack_chars("ABCDEFGH"), 24'(pack_chars("XYZ")), DIR_MASK, '1);
      send_entry(1'b0, pack_chars(""), 24'(pack_chars("")), ATTR_ARCHIVE, '0);
      base = pack_chars("AB CDEFG");
      base[23:16] = fde_pkg::CHAR_NUL;
      ext = 24'(pack_chars("C D"));
      ext[15:8] = fde_pkg::CHAR_NUL;
      send_entry(1'b0, base, ext, 8'h01, 32'h8000_0001);
      // blank first extension byte hides the rest of the extension
      send_entry(1'b0, pack_chars("NOEXT"), 24'(pack_chars(" AB")), 8'h02, 32'd7);
      // NUL first extension byte still gives a dot
      send_entry(1'b0, pack_chars("DOT"), 24'h0, ATTR_ARCHIVE, 32'd9);
      send_entry(1'b0, pack_chars("A B"), 24'(pack_chars("X Y")), 8'h04, 32'h5555_AAAA);
      base = pack_chars("GONE");
      base[7:0] = fde_pkg::CHAR_DEL;
      send_entry(1'b0, base, 24'(pack_chars("TMP")), ATTR_ARCHIVE, 32'd1);
      send_entry(1'b0, pack_chars("LONGNAME"), 24'(pack_chars("ABC")), fde_pkg::ATTR_LFN,
                 32'd2);
      send_entry(1'b0, pack_chars("VOLUME"), 24'(pack_chars("LBL")), VOLUME_MASK, 32'd3);
      send_entry(1'b0, pack_chars("ALLATTR"), 24'(pack_chars("BIN")), 8'hFF, 32'd4);
      send_entry(1'b0, '1, '1, 8'hF7, 32'hAAAA_5555);
      send_entry(1'b0, 64'h0, 24'h0, 8'h00, 32'h0);
      send_entry(1'b0, pack_chars("LATE"), 24'(pack_chars("DAT")), ATTR_ARCHIVE, 32'd5);
      // new directory that is empty from the start
      send_entry(1'b1, 64'hFFFF_FFFF_FFFF_FF00, '1, '1, '1);

      // skip two, list at most three; the end marker is then withheld
      set_config(16'd2, 16'd3);
      for (int i = 0; i < 7; i++)
         send_entry(i == 0, pick_base(), pick_ext(), ATTR_ARCHIVE, $urandom);
      send_entry(1'b0, 64'h0, 24'h0, 8'h00, 32'h0);

      set_config(16'd0, 16'd0);
      send_entry(1'b1, pack_chars("HIDDEN"), 24'(pack_chars("SYS")), ATTR_ARCHIVE, 32'd6);
      send_entry(1'b0, 64'h0, 24'h0, 8'h00, 32'h0);

      // random directories under changing settings
      phase = 0;
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         phase++;
         skip = ($urandom_range(3) == 0) ? fde_pkg::cfg_type'(0) :
                                           fde_pkg::cfg_type'($urandom_range(4));
         case ($urandom_range(5))
            0:       limit = '1;
            1:       limit = '0;
            default: limit = fde_pkg::cfg_type'($urandom_range(8, 1));
         endcase
         set_config(skip, limit);
         quiet = (phase == 3);
         repeat ($urandom_range(4, 1)) run_directory($urandom_range(14));
         if (phase == 3) repeat (4) run_directory(12);
         quiet = 1'b0;
      end

      settle();
      $display("Covered %0d entry beats over %0d register settings, %0d listing beats checked,",
               entry_beats, settings, beats_checked);
      $display("with directed naming, skip and limit cases and random stalls on both sides.");
      if (fail_count == 0 && pending_beats == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches, %0d listing beats missing", fail_count, pending_beats);
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/fde_pkg.sv
rtl/fde_if.sv
rtl/fde_front.sv
rtl/fde_queue.sv
rtl/fde_back.sv
rtl/fat_dir_entry_decoder_core.sv
rtl/fde_checker.sv
dv/fde_listing_checker.sv
dv/tb_fat_dir_entry_decoder_core.sv
